FILE: design/nfsn_pkg.sv
// ----------------------------------------------------------------------------
// nfsn_pkg
// shared constants and types for the 5-smooth number generator
// ----------------------------------------------------------------------------
`default_nettype none

package nfsn_pkg;

   localparam int MAX_INDEX   = 1024;
   localparam int TABLE_DEPTH = MAX_INDEX + 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int POS_W       = 12;
   localparam int VALUE_W     = 32;
   localparam int CAND_W      = VALUE_W + 3;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [VALUE_W-1:0] value_type;

   // outcome of one merge step
   typedef struct packed {
      value_type value;
      logic      adv_two;
      logic      adv_three;
      logic      adv_five;
   } merge_type;

endpackage

`default_nettype wire

FILE: design/nth_five_smooth_number_core.sv
// ----------------------------------------------------------------------------
// nth_five_smooth_number_core
// returns the n-th 5-smooth number by a three-pointer merge over a table
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_position[11:0]
//  rsp      out  rsp_valid/rsp_stall   rsp_smooth_value[31:0], rsp_out_of_range
//
//  one item at a time; position 0, 1 or out of range passes through the
//  result register to the output register; otherwise the core does one
//  merge/write step per entry 2..n plus one table read for each pointer
//  advance over entries 2..n-1, paced by the single table read port.
//  synchronous reset clears the control; the table needs no clearing.
//  a finished result waits in its own register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nth_five_smooth_number_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [nfsn_pkg::POS_W-1:0] req_position,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output nfsn_pkg::value_type          rsp_smooth_value,
   output logic                         rsp_out_of_range
);
   import nfsn_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPUTE = 2'd1;
   localparam logic [1:0] ST_FETCH   = 2'd2;
   localparam logic [1:0] ST_DELIVER = 2'd3;

   localparam logic [1:0] SEL_TWO   = 2'd0;
   localparam logic [1:0] SEL_THREE = 2'd1;
   localparam logic [1:0] SEL_FIVE  = 2'd2;

   logic [1:0] state_ff, state_in;
   addr_type   p_two_ff, p_two_in;
   addr_type   p_three_ff, p_three_in;
   addr_type   p_five_ff, p_five_in;
   value_type  v_two_ff, v_two_in;
   value_type  v_three_ff, v_three_in;
   value_type  v_five_ff, v_five_in;
   addr_type   idx_ff, idx_in;
   addr_type   target_ff, target_in;
   logic       pend_two_ff, pend_two_in;
   logic       pend_three_ff, pend_three_in;
   logic       pend_five_ff, pend_five_in;
   logic       land_vld_ff, land_vld_in;
   logic [1:0] land_sel_ff, land_sel_in;
   value_type  res_value_ff, res_value_in;
   logic       res_oor_ff, res_oor_in;
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff, rsp_value_in;
   logic       rsp_oor_ff, rsp_oor_in;

   logic       mem_wr_en;
   addr_type   mem_wr_addr;
   value_type  mem_wr_data;
   logic       mem_rd_en;
   addr_type   mem_rd_addr;
   value_type  mem_rd_data;

   value_type  eff_two;
   value_type  eff_three;
   value_type  eff_five;
   merge_type  merge;
   logic       req_accept;

   nfsn_table u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // read data landing this cycle bypasses the operand register
   assign eff_two   = (land_vld_ff && land_sel_ff == SEL_TWO)   ? mem_rd_data : v_two_ff;
   assign eff_three = (land_vld_ff && land_sel_ff == SEL_THREE) ? mem_rd_data : v_three_ff;
   assign eff_five  = (land_vld_ff && land_sel_ff == SEL_FIVE)  ? mem_rd_data : v_five_ff;

   nfsn_merge u_merge (
      .val_two   (eff_two),
      .val_three (eff_three),
      .val_five  (eff_five),
      .result    (merge)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_accept       = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_smooth_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   always_comb begin
      state_in      = state_ff;
      p_two_in      = p_two_ff;
      p_three_in    = p_three_ff;
      p_five_in     = p_five_ff;
      v_two_in      = v_two_ff;
      v_three_in    = v_three_ff;
      v_five_in     = v_five_ff;
      idx_in        = idx_ff;
      target_in     = target_ff;
      pend_two_in   = pend_two_ff;
      pend_three_in = pend_three_ff;
      pend_five_in  = pend_five_ff;
      land_vld_in   = 1'b0;
      land_sel_in   = land_sel_ff;
      res_value_in  = res_value_ff;
      res_oor_in    = res_oor_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_oor_in    = rsp_oor_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = merge.value;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = p_two_ff;

      if (land_vld_ff) begin
         unique case (land_sel_ff)
            SEL_TWO:   v_two_in   = mem_rd_data;
            SEL_THREE: v_three_in = mem_rd_data;
            SEL_FIVE:  v_five_in  = mem_rd_data;
            default:   v_two_in   = v_two_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_oor_in = 1'b0;
               priority if (req_position == '0) begin
                  res_value_in = '0;
                  state_in     = ST_DELIVER;
               end else if (req_position > POS_W'(MAX_INDEX)) begin
                  res_value_in = '0;
                  res_oor_in   = 1'b1;
                  state_in     = ST_DELIVER;
               end else if (req_position == POS_W'(1)) begin
                  res_value_in = VALUE_W'(1);
                  state_in     = ST_DELIVER;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ADDR_W'(1);
                  mem_wr_data = VALUE_W'(1);
                  p_two_in    = ADDR_W'(1);
                  p_three_in  = ADDR_W'(1);
                  p_five_in   = ADDR_W'(1);
                  v_two_in    = VALUE_W'(1);
                  v_three_in  = VALUE_W'(1);
                  v_five_in   = VALUE_W'(1);
                  idx_in      = ADDR_W'(2);
                  target_in   = req_position[ADDR_W-1:0];
                  state_in    = ST_COMPUTE;
               end
            end
         end
         ST_COMPUTE: begin
            mem_wr_en = 1'b1;
            if (idx_ff == target_ff) begin
               res_value_in = merge.value;
               res_oor_in   = 1'b0;
               state_in     = ST_DELIVER;
            end else begin
               pend_two_in   = merge.adv_two;
               pend_three_in = merge.adv_three;
               pend_five_in  = merge.adv_five;
               p_two_in      = p_two_ff + ADDR_W'(merge.adv_two);
               p_three_in    = p_three_ff + ADDR_W'(merge.adv_three);
               p_five_in     = p_five_ff + ADDR_W'(merge.adv_five);
               idx_in        = idx_ff + ADDR_W'(1);
               state_in      = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // one pointer refill per cycle, data lands next cycle
            mem_rd_en   = 1'b1;
            land_vld_in = 1'b1;
            priority if (pend_two_ff) begin
               mem_rd_addr = p_two_ff;
               land_sel_in = SEL_TWO;
               pend_two_in = 1'b0;
            end else if (pend_three_ff) begin
               mem_rd_addr   = p_three_ff;
               land_sel_in   = SEL_THREE;
               pend_three_in = 1'b0;
            end else begin
               mem_rd_addr  = p_five_ff;
               land_sel_in  = SEL_FIVE;
               pend_five_in = 1'b0;
            end
            if (!pend_two_in && !pend_three_in && !pend_five_in) begin
               state_in = ST_COMPUTE;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_two_ff   <= 1'b0;
         pend_three_ff <= 1'b0;
         pend_five_ff  <= 1'b0;
         land_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         p_two_ff      <= ADDR_W'(1);
         p_three_ff    <= ADDR_W'(1);
         p_five_ff     <= ADDR_W'(1);
      end else begin
         state_ff      <= state_in;
         pend_two_ff   <= pend_two_in;
         pend_three_ff <= pend_three_in;
         pend_five_ff  <= pend_five_in;
         land_vld_ff   <= land_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         p_two_ff      <= p_two_in;
         p_three_ff    <= p_three_in;
         p_five_ff     <= p_five_in;
      end
   end

   always_ff @(posedge clock) begin
      v_two_ff     <= v_two_in;
      v_three_ff   <= v_three_in;
      v_five_ff    <= v_five_in;
      idx_ff       <= idx_in;
      target_ff    <= target_in;
      land_sel_ff  <= land_sel_in;
      res_value_ff <= res_value_in;
      res_oor_ff   <= res_oor_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

endmodule

`default_nettype wire

FILE: design/nfsn_table.sv
// ----------------------------------------------------------------------------
// nfsn_table
// sequence table: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module nfsn_table (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire nfsn_pkg::addr_type  wr_addr,
   input  wire nfsn_pkg::value_type wr_data,
   input  wire logic              rd_en,
   input  wire nfsn_pkg::addr_type  rd_addr,
   output nfsn_pkg::value_type    rd_data
);
   import nfsn_pkg::*;

   value_type mem [TABLE_DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/nfsn_merge.sv
// ----------------------------------------------------------------------------
// nfsn_merge
// forms the three candidates, picks the minimum and flags pointer advances
// ----------------------------------------------------------------------------
`default_nettype none

module nfsn_merge (
   input  wire nfsn_pkg::value_type val_two,
   input  wire nfsn_pkg::value_type val_three,
   input  wire nfsn_pkg::value_type val_five,
   output nfsn_pkg::merge_type      result
);
   import nfsn_pkg::*;

   logic [CAND_W-1:0] cand_two;
   logic [CAND_W-1:0] cand_three;
   logic [CAND_W-1:0] cand_five;
   logic [CAND_W-1:0] min_23;
   logic [CAND_W-1:0] min_all;

   // constant multiplies as shift and add
   assign cand_two   = CAND_W'(val_two) << 1;
   assign cand_three = (CAND_W'(val_three) << 1) + CAND_W'(val_three);
   assign cand_five  = (CAND_W'(val_five) << 2) + CAND_W'(val_five);

   assign min_23  = (cand_three < cand_two) ? cand_three : cand_two;
   assign min_all = (cand_five < min_23) ? cand_five : min_23;

   assign result.value     = min_all[VALUE_W-1:0];
   assign result.adv_two   = (cand_two == min_all);
   assign result.adv_three = (cand_three == min_all);
   assign result.adv_five  = (cand_five == min_all);

endmodule

`default_nettype wire

FILE: dv/nth_five_smooth_number_core_test.sv
// ----------------------------------------------------------------------------
// nth_five_smooth_number_core_test
// self-checking bench for the 5-smooth number core: each accepted position is
// predicted by a local three-pointer merge and checked against the response,
// under random sender gaps, random response stalls and one long output hold
// ----------------------------------------------------------------------------

module nth_five_smooth_number_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import nfsn_pkg::*;

   typedef struct {
      logic [POS_W-1:0] position;
      value_type        smooth_value;
      logic             out_of_range;
   } smooth_expect_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [POS_W-1:0] req_position = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   value_type        rsp_smooth_value;
   logic             rsp_out_of_range;

   smooth_expect_type pending_smooth[$];
   int                mismatch_count = 0;

   // local copy of the generator state
   value_type         smooth_table [0:TABLE_DEPTH-1];
   logic [10:0]       ptr_two = 11'd1;
   logic [10:0]       ptr_three = 11'd1;
   logic [10:0]       ptr_five = 11'd1;

   // response stall control
   bit                stall_enable = 1'b0;
   int                hold_request = 0;
   int                hold_left = 0;
   int                burst_left = 0;

   nth_five_smooth_number_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_smooth_value (rsp_smooth_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // three-pointer merge, regenerated from scratch for each query
   function automatic smooth_expect_type predict_smooth(input logic [POS_W-1:0] position);
      smooth_expect_type result;
      logic [CAND_W-1:0] cand_two;
      logic [CAND_W-1:0] cand_three;
      logic [CAND_W-1:0] cand_five;
      logic [CAND_W-1:0] least;
      result.position     = position;
      result.smooth_value = '0;
      result.out_of_range = 1'b0;
      if (position > MAX_INDEX) begin
         result.out_of_range = 1'b1;
      end else if (position != 0) begin
         smooth_table[1] = VALUE_W'(1);
         ptr_two   = 11'd1;
         ptr_three = 11'd1;
         ptr_five  = 11'd1;
         for (int i = 2; i <= position; i++) begin
            cand_two   = CAND_W'(smooth_table[ptr_two]) * 2;
            cand_three = CAND_W'(smooth_table[ptr_three]) * 3;
            cand_five  = CAND_W'(smooth_table[ptr_five]) * 5;
            least = cand_two;
            if (cand_three < least) least = cand_three;
            if (cand_five < least) least = cand_five;
            smooth_table[i] = least[VALUE_W-1:0];
            // every pointer that produced the minimum moves on, so duplicates drop out
            if (cand_two == least) ptr_two = ptr_two + 11'd1;
            if (cand_three == least) ptr_three = ptr_three + 11'd1;
            if (cand_five == least) ptr_five = ptr_five + 11'd1;
         end
         result.smooth_value = smooth_table[position[ADDR_W-1:0]];
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // response side: random stall bursts plus a long hold on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else if (burst_left > 0) begin
         rsp_stall = 1'b1;
         burst_left = burst_left - 1;
      end else begin
         rsp_stall = 1'b0;
         if (stall_enable && $urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 14);
      end
   end

   // checks each response first, then records the prediction for a new item
   always @(posedge clock) begin : monitor
      smooth_expect_type oldest;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_smooth.size() == 0) begin
               report_mismatch($sformatf("response %0h/%0b with no item outstanding",
                                         rsp_smooth_value, rsp_out_of_range));
            end else begin
               oldest = pending_smooth.pop_front();
               if (rsp_smooth_value !== oldest.smooth_value)
                  report_mismatch($sformatf("position %0d smooth_value %0h, expected %0h",
                                            oldest.position, rsp_smooth_value,
                                            oldest.smooth_value));
               if (rsp_out_of_range !== oldest.out_of_range)
                  report_mismatch($sformatf("position %0d out_of_range %0b, expected %0b",
                                            oldest.position, rsp_out_of_range,
                                            oldest.out_of_range));
            end
         end
         if (req_valid && !req_stall) pending_smooth.push_back(predict_smooth(req_position));
      end
   end

   // offers one item, optionally after a random idle burst, and waits for acceptance
   task automatic send_item(input logic [POS_W-1:0] position, input bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_position = position;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_smooth.size() != 0) @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] pick_position(input int k);
      int roll;
      roll = $urandom_range(0, 99);
      // the slow end of the range only now and then
      if (k % 25 == 12) return POS_W'($urandom_range(MAX_INDEX - 64, MAX_INDEX));
      if (roll < 4) return '0;
      if (roll < 9) return POS_W'($urandom_range(MAX_INDEX + 1, 4095));
      if (roll < 24) return POS_W'($urandom_range(2, 300));
      return POS_W'($urandom_range(1, 40));
   endfunction

   task automatic test_directed();
      int corner [$];
      // zero, first entries, shared products of 2*3, 2*6/3*4, 3*5, the table end and out of range
      corner = '{0, 1, 2, 3, 4, 5, 6, 7, 10, 11, 30, 100,
                 MAX_INDEX - 1, MAX_INDEX, MAX_INDEX + 1,
                 12'h555, 12'h7FF, 12'h800, 12'hAAA, 12'hFFF, 1};
      stall_enable = 1'b1;
      foreach (corner[i]) send_item(POS_W'(corner[i]), 1'b1);
      wait_until_drained();
   endtask

   // sender stops and waits for every outstanding response between groups
   task automatic test_drain_pause();
      for (int g = 0; g < 3; g++) begin
         for (int i = 0; i < 4; i++) send_item(POS_W'($urandom_range(1, 60)), 1'b0);
         wait_until_drained();
      end
   endtask

   // long response hold while items keep coming, so the core backs up
   task automatic test_output_hold();
      stall_enable = 1'b0;
      @(posedge clock);
      hold_request = 400;
      for (int i = 0; i < 10; i++) send_item(POS_W'($urandom_range(1, 20)), 1'b0);
      wait_until_drained();
   endtask

   task automatic test_random();
      bit quiet;
      for (int k = 0; k < 500; k++) begin
         // every fourth stretch runs with no idling on either side
         quiet = ((k / 40) % 4) == 3;
         stall_enable = !quiet;
         send_item(pick_position(k), !quiet);
      end
   endtask

   task automatic test_steady_tail();
      stall_enable = 1'b0;
      for (int k = 0; k < 40; k++) send_item(pick_position(k), 1'b0);
      wait_until_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_drain_pause();
      test_output_hold();
      test_random();
      test_steady_tail();
      repeat (3000) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d responses outstanding", pending_smooth.size());
      $display("status: fail");
      $finish;
   end

endmodule
